>>> rtl/core/hcm_pkg.sv
package hcm_pkg;

  localparam int COORD_BITS     = 12;
  localparam int COEF_FRAC_BITS = 16;
  localparam int OUT_FRAC_BITS  = 12;

  localparam int COEF_W  = 32;
  localparam int CFG_W   = 64;
  localparam int IDX_W   = 3;
  localparam int PROD_W  = COEF_W + COORD_BITS + 1;
  localparam int SUM_W   = PROD_W + 2;
  localparam int MAG_W   = SUM_W;
  localparam int QUO_W   = 32;
  localparam int NUM_CELLS = QUO_W;

  localparam logic [IDX_W-1:0] REG_H00_H01 = 3'd0;
  localparam logic [IDX_W-1:0] REG_H02_H10 = 3'd1;
  localparam logic [IDX_W-1:0] REG_H11_H12 = 3'd2;
  localparam logic [IDX_W-1:0] REG_H20_H21 = 3'd3;
  localparam logic [IDX_W-1:0] REG_H22     = 3'd4;

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;
  localparam logic [QUO_W-1:0]  POS_LIMIT = {1'b0, {(QUO_W-1){1'b1}}};
  localparam logic [QUO_W-1:0]  NEG_LIMIT = {1'b1, {(QUO_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COEF_W-1:0] h00, h01, h02;
    logic signed [COEF_W-1:0] h10, h11, h12;
    logic signed [COEF_W-1:0] h20, h21, h22;
  } coef_set_t;

  // One item on its way through the divider cells
  typedef struct packed {
    logic [MAG_W-1:0] den;
    logic [MAG_W-1:0] part_x;
    logic [MAG_W-1:0] part_y;
    logic [QUO_W-1:0] low_x;
    logic [QUO_W-1:0] low_y;
    logic [QUO_W-1:0] quo_x;
    logic [QUO_W-1:0] quo_y;
    logic             neg_x;
    logic             neg_y;
    logic             ovf_x;
    logic             ovf_y;
    logic             zero;
  } div_t;

endpackage

>>> rtl/core/hcm_front.sv
module hcm_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic                              in_ok,
  input  logic [hcm_pkg::COORD_BITS-1:0]    col,
  input  logic [hcm_pkg::COORD_BITS-1:0]    row,
  input  hcm_pkg::coef_set_t                coef,
  output logic                              div_valid,
  output hcm_pkg::div_t                     div_data
);

  localparam int PW = hcm_pkg::PROD_W;
  localparam int SW = hcm_pkg::SUM_W;
  localparam int MW = hcm_pkg::MAG_W;
  localparam int F  = hcm_pkg::OUT_FRAC_BITS;

  logic signed [hcm_pkg::COORD_BITS:0] col_s, row_s;

  // stage a: products
  logic               a_valid;
  logic signed [PW-1:0] p00, p01, p10, p11, p20, p21, c02, c12, c22;

  // stage b: sums
  logic               b_valid;
  logic signed [SW-1:0] nx, ny, z;

  logic [MW-1:0] mag_x, mag_y, mag_z;
  logic [MW-1:0] hi_x, hi_y;
  hcm_pkg::div_t first;

  assign col_s = $signed({1'b0, col});
  assign row_s = $signed({1'b0, row});

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      div_valid <= 1'b0;
    end else if (advance) begin
      a_valid   <= in_ok;
      b_valid   <= a_valid;
      div_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p00 <= PW'(coef.h00 * col_s);
      p01 <= PW'(coef.h01 * row_s);
      p10 <= PW'(coef.h10 * col_s);
      p11 <= PW'(coef.h11 * row_s);
      p20 <= PW'(coef.h20 * col_s);
      p21 <= PW'(coef.h21 * row_s);
      c02 <= PW'(coef.h02);
      c12 <= PW'(coef.h12);
      c22 <= PW'(coef.h22);

      nx <= SW'(p00) + SW'(p01) + SW'(c02);
      ny <= SW'(p10) + SW'(p11) + SW'(c12);
      z  <= SW'(p20) + SW'(p21) + SW'(c22);

      div_data <= first;
    end
  end

  always_comb begin
    mag_x = nx[SW-1] ? MW'(-nx) : MW'(nx);
    mag_y = ny[SW-1] ? MW'(-ny) : MW'(ny);
    mag_z = z[SW-1]  ? MW'(-z)  : MW'(z);
    // dividend is mag << F; the part above the quotient width seeds the remainder
    hi_x  = mag_x >> (hcm_pkg::QUO_W - F);
    hi_y  = mag_y >> (hcm_pkg::QUO_W - F);

    first.den    = mag_z;
    first.part_x = hi_x;
    first.part_y = hi_y;
    first.low_x  = {mag_x[hcm_pkg::QUO_W-F-1:0], {F{1'b0}}};
    first.low_y  = {mag_y[hcm_pkg::QUO_W-F-1:0], {F{1'b0}}};
    first.quo_x  = '0;
    first.quo_y  = '0;
    first.neg_x  = nx[SW-1] ^ z[SW-1];
    first.neg_y  = ny[SW-1] ^ z[SW-1];
    first.ovf_x  = (hi_x >= mag_z);
    first.ovf_y  = (hi_y >= mag_z);
    first.zero   = (mag_z == '0);
  end

endmodule

>>> rtl/core/hcm_div_cell.sv
module hcm_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic          prev_valid,
  input  hcm_pkg::div_t prev,
  output logic          cell_valid,
  output hcm_pkg::div_t cell_data
);

  localparam int MW = hcm_pkg::MAG_W;
  localparam int QW = hcm_pkg::QUO_W;

  logic [MW:0]   sh_x, sh_y;
  logic          ge_x, ge_y;
  hcm_pkg::div_t nxt;

  always_comb begin
    // bring in the next dividend bit, subtract the divisor where it fits
    sh_x = {prev.part_x, prev.low_x[QW-1]};
    sh_y = {prev.part_y, prev.low_y[QW-1]};
    ge_x = (sh_x >= {1'b0, prev.den});
    ge_y = (sh_y >= {1'b0, prev.den});
    nxt        = prev;
    nxt.part_x = ge_x ? MW'(sh_x - {1'b0, prev.den}) : MW'(sh_x);
    nxt.part_y = ge_y ? MW'(sh_y - {1'b0, prev.den}) : MW'(sh_y);
    nxt.low_x  = {prev.low_x[QW-2:0], 1'b0};
    nxt.low_y  = {prev.low_y[QW-2:0], 1'b0};
    nxt.quo_x  = {prev.quo_x[QW-2:0], ge_x};
    nxt.quo_y  = {prev.quo_y[QW-2:0], ge_y};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (advance) begin
      cell_valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cell_data <= nxt;
    end
  end

endmodule

>>> rtl/core/homography_coordinate_map.sv
// Maps a destination pixel (pixel_col, pixel_row) through a 3x3 projective
// matrix of signed Q16.16 coefficients and returns source_col and source_row
// as signed Q20.12, truncated toward zero and saturated, with not_mappable
// set for a zero denominator or a saturated quotient. One item enters per
// clock while in_stall is low. Each item passes three stages of products,
// sums and divider setup (the first loads at the edge that takes it), then
// one per quotient bit in a row of 32 divider cells, and then the output
// register. The whole pipeline holds while a result waits under out_stall.
// Write coefficients only while no item is in flight.
module homography_coordinate_map (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [hcm_pkg::IDX_W-1:0]           cfg_index,
  input  logic [hcm_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [hcm_pkg::COORD_BITS-1:0]      pixel_col,
  input  logic [hcm_pkg::COORD_BITS-1:0]      pixel_row,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [hcm_pkg::QUO_W-1:0]    source_col,
  output logic signed [hcm_pkg::QUO_W-1:0]    source_row,
  output logic                                not_mappable
);

  localparam int CW = hcm_pkg::COEF_W;
  localparam int QW = hcm_pkg::QUO_W;
  localparam int NC = hcm_pkg::NUM_CELLS;

  logic [hcm_pkg::CFG_W-1:0] coef_h00_h01, coef_h02_h10, coef_h11_h12, coef_h20_h21;
  logic [CW-1:0]             coef_h22;
  hcm_pkg::coef_set_t        coef;

  logic advance;

  logic          chain_valid [NC+1];
  hcm_pkg::div_t chain       [NC+1];

  hcm_pkg::div_t  last;
  logic [QW-1:0]  lim_x, lim_y, mag_x, mag_y;
  logic           sat_x, sat_y;
  logic [QW-1:0]  res_x, res_y;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_h00_h01 <= {hcm_pkg::COEF_ONE, {CW{1'b0}}};
      coef_h02_h10 <= '0;
      coef_h11_h12 <= {hcm_pkg::COEF_ONE, {CW{1'b0}}};
      coef_h20_h21 <= '0;
      coef_h22     <= hcm_pkg::COEF_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hcm_pkg::REG_H00_H01: coef_h00_h01 <= cfg_data;
        hcm_pkg::REG_H02_H10: coef_h02_h10 <= cfg_data;
        hcm_pkg::REG_H11_H12: coef_h11_h12 <= cfg_data;
        hcm_pkg::REG_H20_H21: coef_h20_h21 <= cfg_data;
        hcm_pkg::REG_H22:     coef_h22     <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    coef.h00 = $signed(coef_h00_h01[2*CW-1:CW]);
    coef.h01 = $signed(coef_h00_h01[CW-1:0]);
    coef.h02 = $signed(coef_h02_h10[2*CW-1:CW]);
    coef.h10 = $signed(coef_h02_h10[CW-1:0]);
    coef.h11 = $signed(coef_h11_h12[2*CW-1:CW]);
    coef.h12 = $signed(coef_h11_h12[CW-1:0]);
    coef.h20 = $signed(coef_h20_h21[2*CW-1:CW]);
    coef.h21 = $signed(coef_h20_h21[CW-1:0]);
    coef.h22 = $signed(coef_h22);
  end

  hcm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_ok     (in_valid),
    .col       (pixel_col),
    .row       (pixel_row),
    .coef      (coef),
    .div_valid (chain_valid[0]),
    .div_data  (chain[0])
  );

  for (genvar i = 0; i < NC; i++) begin : g_cell
    hcm_div_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .prev_valid (chain_valid[i]),
      .prev       (chain[i]),
      .cell_valid (chain_valid[i+1]),
      .cell_data  (chain[i+1])
    );
  end

  always_comb begin
    last  = chain[NC];
    lim_x = last.neg_x ? hcm_pkg::NEG_LIMIT : hcm_pkg::POS_LIMIT;
    lim_y = last.neg_y ? hcm_pkg::NEG_LIMIT : hcm_pkg::POS_LIMIT;
    sat_x = last.ovf_x || (last.quo_x > lim_x);
    sat_y = last.ovf_y || (last.quo_y > lim_y);
    mag_x = sat_x ? lim_x : last.quo_x;
    mag_y = sat_y ? lim_y : last.quo_y;
    res_x = last.neg_x ? QW'(-mag_x) : mag_x;
    res_y = last.neg_y ? QW'(-mag_y) : mag_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= chain_valid[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      // drop both coordinates to zero when the denominator vanishes
      source_col   <= last.zero ? '0 : $signed(res_x);
      source_row   <= last.zero ? '0 : $signed(res_y);
      not_mappable <= last.zero || sat_x || sat_y;
    end
  end

endmodule

>>> tb/sv/tb_homography_coordinate_map.sv
module tb_homography_coordinate_map;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [hcm_pkg::IDX_W-1:0] REG_NONE = 3'd5;

  typedef struct {
    logic signed [31:0] col;
    logic signed [31:0] row;
    logic               bad;
  } mapped_pt_t;

  // Coefficient shadow plus queue of predicted mapped points
  class map_scoreboard;
    logic [63:0] r01, r0210, r1112, r2021;
    logic [31:0] r22;
    mapped_pt_t  pending[$];
    int          errors;
    int          checked;
    int          flagged;

    function void set_reset();
      r01 = {hcm_pkg::COEF_ONE, 32'h0};
      r0210 = '0;
      r1112 = {hcm_pkg::COEF_ONE, 32'h0};
      r2021 = '0;
      r22 = hcm_pkg::COEF_ONE;
    endfunction

    function void write_reg(logic [hcm_pkg::IDX_W-1:0] idx, logic [63:0] val);
      case (idx)
        hcm_pkg::REG_H00_H01: r01 = val;
        hcm_pkg::REG_H02_H10: r0210 = val;
        hcm_pkg::REG_H11_H12: r1112 = val;
        hcm_pkg::REG_H20_H21: r2021 = val;
        hcm_pkg::REG_H22:     r22 = val[31:0];
        default: ;
      endcase
    endfunction

    // Truncating fixed-point quotient with saturation
    function logic [31:0] fx_quot(longint num, longint den, ref bit sat);
      bit neg;
      logic [63:0] n, d, q, rm, m, lim;
      neg = (num < 0) != (den < 0);
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      q = n / d;
      rm = n % d;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (q > (64'h8000_0000 >> hcm_pkg::OUT_FRAC_BITS)) begin
        m = lim + 1;
      end else begin
        m = q;
        for (int i = 0; i < hcm_pkg::OUT_FRAC_BITS; i++) begin
          rm = rm << 1;
          m = m << 1;
          if (rm >= d) begin
            rm = rm - d;
            m[0] = 1'b1;
          end
        end
      end
      if (m > lim) begin
        sat = 1;
        m = lim;
      end
      if (neg) m = -m;
      return m[31:0];
    endfunction

    function void note_pixel(logic [11:0] c, logic [11:0] r);
      longint cc, rr, z, nx, ny;
      bit sat;
      mapped_pt_t e;
      cc = c;
      rr = r;
      z  = longint'($signed(r2021[63:32])) * cc + longint'($signed(r2021[31:0])) * rr
         + longint'($signed(r22));
      nx = longint'($signed(r01[63:32])) * cc + longint'($signed(r01[31:0])) * rr
         + longint'($signed(r0210[63:32]));
      ny = longint'($signed(r0210[31:0])) * cc + longint'($signed(r1112[63:32])) * rr
         + longint'($signed(r1112[31:0]));
      sat = 0;
      if (z == 0) begin
        e.col = 0;
        e.row = 0;
        e.bad = 1;
      end else begin
        e.col = fx_quot(nx, z, sat);
        e.row = fx_quot(ny, z, sat);
        e.bad = sat;
      end
      pending.push_back(e);
    endfunction

    function void check_point(logic [31:0] c, logic [31:0] r, logic b);
      mapped_pt_t e;
      checked++;
      if (b) flagged++;
      if (pending.size() == 0) begin
        report_bad("unexpected item", c, r);
        return;
      end
      e = pending.pop_front();
      if (c !== e.col) report_bad("source_col", c, e.col);
      if (r !== e.row) report_bad("source_row", r, e.row);
      if (b !== e.bad) report_bad("not_mappable", b, e.bad);
    endfunction

    function void report_bad(string f, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch #%0d on %s: got %h want %h", checked, f, got, want);
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [hcm_pkg::IDX_W-1:0] cfg_index = '0;
  logic [hcm_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  logic [hcm_pkg::COORD_BITS-1:0] pixel_col = '0, pixel_row = '0;
  logic out_valid, out_stall = 0;
  logic signed [31:0] source_col, source_row;
  logic not_mappable;

  map_scoreboard sb;
  bit quiet_phase = 0;
  bit hold_rx = 0;
  int idle_cycles = 0;
  int sent = 0;

  homography_coordinate_map dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      sb.note_pixel(pixel_col, pixel_row);
      sent++;
    end
    if (!rst && out_valid && !out_stall) sb.check_point(source_col, source_row, not_mappable);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 20000) begin
      $display("watchdog expired");
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stall bursts outside the quiet phase, unless a long hold is requested
  always @(negedge clk) begin
    if (hold_rx) out_stall <= 1;
    else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      out_stall <= 1;
      repeat ($urandom_range(1, 4) - 1) @(negedge clk);
    end else out_stall <= 0;
  end

  task automatic send_pixel(logic [11:0] c, logic [11:0] r);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1;
    pixel_col <= c;
    pixel_row <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (45) @(negedge clk);
  endtask

  task automatic write_coef(logic [hcm_pkg::IDX_W-1:0] idx, logic [63:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] rand_coef(int mode);
    case (mode)
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return $urandom;
      2: return $signed($urandom_range(0, 8192)) - 4096;
      default: return $signed($urandom_range(0, 262144)) - 131072;
    endcase
  endfunction

  task automatic random_coefs(int mode);
    write_coef(hcm_pkg::REG_H00_H01, {rand_coef(mode), rand_coef(mode)});
    write_coef(hcm_pkg::REG_H02_H10, {rand_coef(mode), rand_coef(mode)});
    write_coef(hcm_pkg::REG_H11_H12, {rand_coef(mode), rand_coef(mode)});
    write_coef(hcm_pkg::REG_H20_H21,
               {rand_coef(mode == 1 ? 2 : mode), rand_coef(mode == 1 ? 2 : mode)});
    write_coef(hcm_pkg::REG_H22, {32'h0, rand_coef(mode)});
  endtask

  initial begin
    sb = new();
    sb.set_reset();
    repeat (3) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Identity at reset, then corners and one inner point
    send_pixel(0, 0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'hFFF, 0);
    send_pixel(0, 12'hFFF);
    send_pixel(12'hAAA, 12'h555);
    drain();
    // Zero denominator everywhere
    write_coef(hcm_pkg::REG_H22, 64'h0);
    send_pixel(7, 9);
    send_pixel(0, 0);
    drain();
    // Zero on a line: z = c - r
    write_coef(hcm_pkg::REG_H20_H21, {32'h0001_0000, 32'hFFFF_0000});
    send_pixel(100, 100);
    send_pixel(101, 100);
    send_pixel(100, 101);
    drain();
    // Tiny denominator saturates both ways, the other coordinate stays sane
    write_coef(hcm_pkg::REG_H20_H21, 64'h0);
    write_coef(hcm_pkg::REG_H22, 64'h1);
    write_coef(hcm_pkg::REG_H00_H01, {32'h7FFF_FFFF, 32'h8000_0000});
    write_coef(hcm_pkg::REG_H02_H10, {32'h8000_0000, 32'h0});
    write_coef(hcm_pkg::REG_H11_H12, {32'h0, 32'h1});
    send_pixel(12'hFFF, 0);
    send_pixel(0, 12'hFFF);
    send_pixel(0, 0);
    drain();
    write_coef(hcm_pkg::REG_H22, 64'hFFFF_FFFF_FFFF_FFFF);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(1, 1);
    drain();
    write_coef(hcm_pkg::REG_H22, {32'h0, 32'h8000_0000});
    send_pixel(5, 3);
    drain();
    write_coef(hcm_pkg::REG_H22, {32'h0, 32'h7FFF_FFFF});
    send_pixel(12'hFFF, 12'hFFF);
    drain();

    // Random phases over different coefficient styles
    for (int ph = 0; ph < 14; ph++) begin
      random_coefs(ph % 4);
      if (ph == 5) begin
        // Long receiver hold while the sender keeps pushing
        hold_rx = 1;
        fork
          begin repeat (150) @(negedge clk); hold_rx = 0; end
          for (int k = 0; k < 100; k++) send_pixel(12'($urandom), 12'($urandom));
        join
      end
      if (ph == 12) quiet_phase = 1;
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 3) == 0)
          send_pixel(12'($urandom_range(0, 15)), 12'($urandom_range(0, 15)));
        else send_pixel(12'($urandom), 12'($urandom));
      end
      drain();
    end
    write_coef(REG_NONE, 64'($urandom));
    send_pixel(3, 4);
    drain();

    $display("sent %0d pixels, checked %0d over directed and 14 random coefficient sets",
             sent, sb.checked);
    $display("%0d results flagged not mappable", sb.flagged);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
